>>> hdl/rlsd_pkg.sv
// shared types and constants for the run-length image span decoder
package rlsd_pkg;

	// phase codes of the decoder
	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_RECORDS = 2'd1;
	localparam logic [1:0] PH_DONE    = 2'd2;

	// header byte positions
	localparam logic [3:0] HDR_WIDTH_HI  = 4'd0;
	localparam logic [3:0] HDR_WIDTH_LO  = 4'd1;
	localparam logic [3:0] HDR_HEIGHT_HI = 4'd2;
	localparam logic [3:0] HDR_HEIGHT_LO = 4'd3;
	localparam logic [3:0] HDR_BYTES     = 4'd10;

	// record byte positions
	localparam logic [1:0] REC_COUNT = 2'd0;
	localparam logic [1:0] REC_BLUE  = 2'd1;
	localparam logic [1:0] REC_GREEN = 2'd2;
	localparam logic [1:0] REC_RED   = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_file;
	} src_item_t;

	typedef struct packed {
		logic [15:0] span_row;
		logic [15:0] span_col;
		logic [7:0]  span_len;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        clipped;
		logic        image_done;
	} span_item_t;

endpackage

>>> hdl/rle_image_span_decoder.sv
// top level of the run-length image span decoder
//
//  channel   | signals                            | carries
//  ----------+------------------------------------+---------------------------
//  source    | src_valid, src_ready, src_item     | one file byte and restart
//  span      | span_valid, span_ready, span_item  | one decoded pixel span
//
// one byte per clock while the span channel does not stall: the byte is registered,
// decoded in a single pass against the state registers and the span lands in
// the output register.
// reset clears the input and output stages and returns the parser to the header.
// a stalled span holds the decode stage; an empty input register still takes
// one more byte, a full one drops src_ready in the same cycle as span_ready.
module rle_image_span_decoder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  src_valid,
	output logic                  src_ready,
	input  rlsd_pkg::src_item_t   src_item,
	output logic                  span_valid,
	input  logic                  span_ready,
	output rlsd_pkg::span_item_t  span_item
);
	import rlsd_pkg::*;

	logic       vld_s1;
	src_item_t  item_s1;
	logic       vld_s2;
	span_item_t span_s2;
	logic       advance;
	logic       res_valid;
	span_item_t res;

	// handshake control
	assign advance   = vld_s1 && (!vld_s2 || span_ready);
	assign src_ready = !vld_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (src_valid && src_ready) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && src_ready) begin
			item_s1 <= src_item;
		end
	end

	rlsd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= res_valid;
		end else if (span_ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			span_s2 <= res;
		end
	end

	assign span_valid = vld_s2;
	assign span_item  = span_s2;

endmodule

>>> hdl/rlsd_core.sv
// decoder state and the single-pass header/record decode logic
module rlsd_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  rlsd_pkg::src_item_t item,
	output logic               res_valid,
	output rlsd_pkg::span_item_t res
);
	import rlsd_pkg::*;

	logic [1:0]  phase_q;
	logic [3:0]  hdr_pos_q;
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [15:0] row_q;
	logic [15:0] col_q;
	logic [1:0]  rec_pos_q;
	logic [7:0]  count_q;
	logic [7:0]  blue_q;
	logic [7:0]  green_q;

	// values after an optional restart
	logic [1:0]  phase_e;
	logic [3:0]  hdr_pos_e;
	logic [15:0] width_e;
	logic [15:0] height_e;
	logic [15:0] row_e;
	logic [15:0] col_e;
	logic [1:0]  rec_pos_e;
	logic [7:0]  count_e;

	// next state
	logic [1:0]  phase_d;
	logic [3:0]  hdr_pos_d;
	logic [15:0] width_d;
	logic [15:0] height_d;
	logic [15:0] row_d;
	logic [15:0] col_d;
	logic [1:0]  rec_pos_d;
	logic [7:0]  count_d;
	logic [7:0]  blue_d;
	logic [7:0]  green_d;

	logic [3:0]  hdr_next;
	logic [15:0] left;
	logic [7:0]  len;
	logic        clip;
	logic [15:0] col_sum;
	logic [15:0] row_inc;

	// restart on start of file
	always_comb begin
		if (item.start_of_file) begin
			phase_e   = PH_HEADER;
			hdr_pos_e = '0;
			width_e   = '0;
			height_e  = '0;
			row_e     = '0;
			col_e     = '0;
			rec_pos_e = REC_COUNT;
			count_e   = '0;
		end else begin
			phase_e   = phase_q;
			hdr_pos_e = hdr_pos_q;
			width_e   = width_q;
			height_e  = height_q;
			row_e     = row_q;
			col_e     = col_q;
			rec_pos_e = rec_pos_q;
			count_e   = count_q;
		end
	end

	// span arithmetic: clip to the columns left, then step column and row
	always_comb begin
		left    = width_e - col_e;
		clip    = ({8'd0, count_e} > left);
		len     = clip ? left[7:0] : count_e;
		col_sum = col_e + {8'd0, len};
		row_inc = row_e + 16'd1;
		hdr_next = hdr_pos_e + 4'd1;
	end

	// decode one byte
	always_comb begin
		phase_d   = phase_e;
		hdr_pos_d = hdr_pos_e;
		width_d   = width_e;
		height_d  = height_e;
		row_d     = row_e;
		col_d     = col_e;
		rec_pos_d = rec_pos_e;
		count_d   = count_e;
		blue_d    = blue_q;
		green_d   = green_q;
		res_valid = 1'b0;
		res       = '0;
		case (phase_e)
			PH_HEADER: begin
				case (hdr_pos_e)
					HDR_WIDTH_HI:  width_d  = {item.data_byte, width_e[7:0]};
					HDR_WIDTH_LO:  width_d  = {width_e[15:8], item.data_byte};
					HDR_HEIGHT_HI: height_d = {item.data_byte, height_e[7:0]};
					HDR_HEIGHT_LO: height_d = {height_e[15:8], item.data_byte};
					default: ;
				endcase
				hdr_pos_d = hdr_next;
				if (hdr_next >= HDR_BYTES) begin
					hdr_pos_d = '0;
					row_d     = '0;
					col_d     = '0;
					rec_pos_d = REC_COUNT;
					if (width_d == 16'd0 || height_d == 16'd0) begin
						// empty image marker
						phase_d        = PH_DONE;
						res_valid      = 1'b1;
						res.image_done = 1'b1;
					end else begin
						phase_d = PH_RECORDS;
					end
				end
			end
			PH_RECORDS: begin
				case (rec_pos_e)
					REC_COUNT: begin
						count_d   = item.data_byte;
						rec_pos_d = REC_BLUE;
					end
					REC_BLUE: begin
						blue_d    = item.data_byte;
						rec_pos_d = REC_GREEN;
					end
					REC_GREEN: begin
						green_d   = item.data_byte;
						rec_pos_d = REC_RED;
					end
					default: begin
						// red byte completes the record
						rec_pos_d = REC_COUNT;
						if (count_e != 8'd0) begin
							res_valid    = 1'b1;
							res.span_row = row_e;
							res.span_col = col_e;
							res.span_len = len;
							res.red      = item.data_byte;
							res.green    = green_q;
							res.blue     = blue_q;
							res.clipped  = clip;
							col_d        = col_sum;
							if (col_sum >= width_e) begin
								col_d = '0;
								row_d = row_inc;
								if (row_inc >= height_e) begin
									res.image_done = 1'b1;
									phase_d        = PH_DONE;
								end
							end
						end
					end
				endcase
			end
			default: ;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_pos_q <= '0;
			width_q   <= '0;
			height_q  <= '0;
			row_q     <= '0;
			col_q     <= '0;
			rec_pos_q <= REC_COUNT;
			count_q   <= '0;
			blue_q    <= '0;
			green_q   <= '0;
		end else if (advance) begin
			phase_q   <= phase_d;
			hdr_pos_q <= hdr_pos_d;
			width_q   <= width_d;
			height_q  <= height_d;
			row_q     <= row_d;
			col_q     <= col_d;
			rec_pos_q <= rec_pos_d;
			count_q   <= count_d;
			blue_q    <= blue_d;
			green_q   <= green_d;
		end
	end

endmodule
